// File: rtl/lzfg_pkg.sv
// ----------------------------------------------------------------------------
// lzfg_pkg
// Shared types and constants of the flag-group LZ decompressor: parser phase,
// the command word passed from the parser to the copy engine, field widths.
// ----------------------------------------------------------------------------
package lzfg_pkg;

   // parser phase
   typedef enum logic [1:0] {
      PH_HEADER = 2'd0,
      PH_FLAG   = 2'd1,
      PH_ITEM   = 2'd2,
      PH_TOKEN  = 2'd3
   } phase_type;

   localparam int BYTE_W = 8;
   localparam int OFF_W  = 15;   // match offset, 1 .. 16384
   localparam int LEN_W  = 6;    // match length, 1 .. 34 after clipping

   localparam logic [2:0]  HEADER_LAST_IDX = 3'd7;
   localparam logic [2:0]  FLAG_LAST_IDX   = 3'd3;
   localparam logic [4:0]  ITEMS_LAST      = 5'd29;   // 30 items per flag word
   localparam logic [13:0] OFFSET_MASK     = 14'h3FFF;
   localparam logic [3:0]  SPLIT_BASE      = 4'd14;
   localparam logic [5:0]  MATCH_MIN       = 6'd3;

   // command queue depth (power of two)
   localparam int QDEPTH = 2;
   localparam int QPTR_W = $clog2(QDEPTH);

   // one command for the copy engine
   typedef struct packed {
      logic                is_copy;
      logic [BYTE_W-1:0]   lit_byte;
      logic [OFF_W-1:0]    offset;
      logic [LEN_W-1:0]    count;
      logic                done;     // last byte of this command ends the stream
   } cmd_type;

endpackage

// File: rtl/lzfg_if.sv
// ----------------------------------------------------------------------------
// lzfg_req_if / lzfg_rsp_if
// Valid/ready channels of the decompressor: compressed bytes in, output out.
// ----------------------------------------------------------------------------
interface lzfg_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] in_byte;

   modport source (output valid, output in_byte, input ready);
   modport sink   (input valid, input in_byte, output ready);
endinterface

interface lzfg_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] out_byte;
   logic       run_last;
   logic       stream_end;

   modport source (output valid, output out_byte, output run_last, output stream_end,
                   input ready);
   modport sink   (input valid, input out_byte, input run_last, input stream_end,
                   output ready);
endinterface

// File: rtl/lzfg_ram.sv
// ----------------------------------------------------------------------------
// lzfg_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module lzfg_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16384
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic                     re,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   // write port, read port returns old data on a same-address write
   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      if (re) begin
         rdata_ff <= mem_ff[raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule

// File: rtl/lzfg_front.sv
// ----------------------------------------------------------------------------
// lzfg_front
// Stream parser: reads header and flag words, classifies each item as a
// literal or a match token and pushes one command per item, clipped at the
// declared output size.
// ----------------------------------------------------------------------------
module lzfg_front (
   input  logic             clock,
   input  logic             reset,
   lzfg_req_if.sink         req_bus,
   input  logic             q_full,
   output logic             q_push,
   output lzfg_pkg::cmd_type q_cmd
);

   lzfg_pkg::phase_type phase_ff, phase_in;
   logic [2:0]  idx_ff, idx_in;
   logic [31:0] rem_ff, rem_in;
   logic [31:0] flags_ff, flags_in;
   logic [4:0]  items_ff, items_in;
   logic [1:0]  split_ff, split_in;
   logic [7:0]  tokhi_ff, tokhi_in;

   logic        accept;
   logic        producing;
   logic [15:0] token;
   logic [13:0] off_mask;
   logic [15:0] len_shift;
   logic [5:0]  match_len;
   logic        match_done;
   logic [5:0]  match_count;
   logic        lit_done;
   logic        item_end;
   logic        item_done;

   // stall only on items that need a queue slot
   assign producing = ((phase_ff == lzfg_pkg::PH_ITEM) && !flags_ff[31]) ||
                      (phase_ff == lzfg_pkg::PH_TOKEN);
   assign req_bus.ready = !(producing && q_full);
   assign accept = req_bus.valid && req_bus.ready;

   // decode match token and clip against the remaining size
   assign token       = {tokhi_ff, req_bus.in_byte};
   assign off_mask    = lzfg_pkg::OFFSET_MASK >> split_ff;
   assign len_shift   = token >> (lzfg_pkg::SPLIT_BASE - {2'b00, split_ff});
   assign match_len   = {1'b0, len_shift[4:0]} + lzfg_pkg::MATCH_MIN;
   assign match_done  = rem_ff <= {26'd0, match_len};
   assign match_count = match_done ? rem_ff[5:0] : match_len;
   assign lit_done    = rem_ff == 32'd1;

   // parse next byte
   always_comb begin
      phase_in  = phase_ff;
      idx_in    = idx_ff;
      rem_in    = rem_ff;
      flags_in  = flags_ff;
      items_in  = items_ff;
      split_in  = split_ff;
      tokhi_in  = tokhi_ff;
      q_push    = 1'b0;
      q_cmd     = '0;
      item_end  = 1'b0;
      item_done = 1'b0;
      if (accept) begin
         unique case (phase_ff)
            lzfg_pkg::PH_HEADER: begin
               case (idx_ff)
                  3'd0:    rem_in = {24'd0, req_bus.in_byte};
                  3'd1:    rem_in[15:8]  = req_bus.in_byte;
                  3'd2:    rem_in[23:16] = req_bus.in_byte;
                  3'd3:    rem_in[31:24] = req_bus.in_byte;
                  default: rem_in = rem_ff;
               endcase
               if (idx_ff == lzfg_pkg::HEADER_LAST_IDX) begin
                  idx_in   = 3'd0;
                  phase_in = (rem_ff == 32'd0) ? lzfg_pkg::PH_HEADER : lzfg_pkg::PH_FLAG;
               end else begin
                  idx_in = idx_ff + 3'd1;
               end
            end
            lzfg_pkg::PH_FLAG: begin
               flags_in = {flags_ff[23:0], req_bus.in_byte};
               if (idx_ff == lzfg_pkg::FLAG_LAST_IDX) begin
                  split_in = req_bus.in_byte[1:0];
                  items_in = 5'd0;
                  idx_in   = 3'd0;
                  phase_in = lzfg_pkg::PH_ITEM;
               end else begin
                  idx_in = idx_ff + 3'd1;
               end
            end
            lzfg_pkg::PH_ITEM: begin
               if (!flags_ff[31]) begin
                  q_push         = 1'b1;
                  q_cmd.is_copy  = 1'b0;
                  q_cmd.lit_byte = req_bus.in_byte;
                  q_cmd.count    = 6'd1;
                  q_cmd.done     = lit_done;
                  rem_in         = rem_ff - 32'd1;
                  item_end       = 1'b1;
                  item_done      = lit_done;
               end else begin
                  tokhi_in = req_bus.in_byte;
                  phase_in = lzfg_pkg::PH_TOKEN;
               end
            end
            lzfg_pkg::PH_TOKEN: begin
               q_push        = 1'b1;
               q_cmd.is_copy = 1'b1;
               q_cmd.offset  = {1'b0, token[13:0] & off_mask} + 15'd1;
               q_cmd.count   = match_count;
               q_cmd.done    = match_done;
               rem_in        = rem_ff - {26'd0, match_count};
               item_end      = 1'b1;
               item_done     = match_done;
            end
         endcase
      end
      // advance to next item, next flag word or next stream
      if (item_end) begin
         if (item_done) begin
            phase_in = lzfg_pkg::PH_HEADER;
            idx_in   = 3'd0;
         end else begin
            flags_in = {flags_ff[30:0], 1'b0};
            items_in = items_ff + 5'd1;
            if (items_ff == lzfg_pkg::ITEMS_LAST) begin
               phase_in = lzfg_pkg::PH_FLAG;
               idx_in   = 3'd0;
            end else begin
               phase_in = lzfg_pkg::PH_ITEM;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= lzfg_pkg::PH_HEADER;
         idx_ff   <= 3'd0;
         rem_ff   <= 32'd0;
         flags_ff <= 32'd0;
         items_ff <= 5'd0;
         split_ff <= 2'd0;
         tokhi_ff <= 8'd0;
      end else begin
         phase_ff <= phase_in;
         idx_ff   <= idx_in;
         rem_ff   <= rem_in;
         flags_ff <= flags_in;
         items_ff <= items_in;
         split_ff <= split_in;
         tokhi_ff <= tokhi_in;
      end
   end

endmodule

// File: rtl/lzfg_cmd_queue.sv
// ----------------------------------------------------------------------------
// lzfg_cmd_queue
// Short FIFO of commands between the parser and the copy engine.
// ----------------------------------------------------------------------------
module lzfg_cmd_queue (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  lzfg_pkg::cmd_type push_cmd,
   output logic              full,
   input  logic              pop,
   output lzfg_pkg::cmd_type head,
   output logic              empty
);

   lzfg_pkg::cmd_type           mem_ff [lzfg_pkg::QDEPTH];
   logic [lzfg_pkg::QPTR_W-1:0] wr_ptr_ff;
   logic [lzfg_pkg::QPTR_W-1:0] rd_ptr_ff;
   logic [lzfg_pkg::QPTR_W:0]   count_ff;

   assign full  = count_ff == (lzfg_pkg::QPTR_W+1)'(lzfg_pkg::QDEPTH);
   assign empty = count_ff == '0;
   assign head  = mem_ff[rd_ptr_ff];

   // store pushed word
   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_cmd;
      end
   end

   // advance pointers and fill count
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push) begin
            wr_ptr_ff <= wr_ptr_ff + lzfg_pkg::QPTR_W'(1);
         end
         if (pop) begin
            rd_ptr_ff <= rd_ptr_ff + lzfg_pkg::QPTR_W'(1);
         end
         if (push && !pop) begin
            count_ff <= count_ff + (lzfg_pkg::QPTR_W+1)'(1);
         end else if (pop && !push) begin
            count_ff <= count_ff - (lzfg_pkg::QPTR_W+1)'(1);
         end
      end
   end

endmodule

// File: rtl/lzfg_back.sv
// ----------------------------------------------------------------------------
// lzfg_back
// Copy engine: executes literal and match commands, reading and writing the
// history RAM; one byte per cycle unless stalled, into an output register.
// ----------------------------------------------------------------------------
module lzfg_back #(
   parameter int HISTORY_DEPTH = 16384
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              q_empty,
   input  lzfg_pkg::cmd_type q_head,
   output logic              q_pop,
   lzfg_rsp_if.source        rsp_bus
);

   localparam int AW = $clog2(HISTORY_DEPTH);
   localparam logic [AW-1:0] LAST_ADDR = AW'(HISTORY_DEPTH - 1);

   // copy sequencer
   logic                     copy_ff, copy_in;
   logic [AW-1:0]            src_ff, src_in;
   logic [lzfg_pkg::LEN_W-1:0] cnt_ff, cnt_in;
   logic                     done_ff, done_in;
   logic [AW-1:0]            ip_ff, ip_in;
   logic [AW-1:0]            wp_ff;

   // read stage
   logic        s1_valid_ff, s1_valid_in;
   logic        s1_lit_ff, s1_lit_in;
   logic [7:0]  s1_byte_ff, s1_byte_in;
   logic        s1_last_ff, s1_last_in;
   logic        s1_end_ff, s1_end_in;
   logic        byp_hit_ff;
   logic [7:0]  byp_data_ff;

   // output register
   logic        out_valid_ff;
   logic [7:0]  out_byte_ff;
   logic        out_last_ff;
   logic        out_end_ff;

   logic          out_free;
   logic          s1_adv;
   logic          issue_ok;
   logic          issue;
   logic          re;
   logic [7:0]    ram_rd;
   logic [7:0]    s1_data;
   logic [AW:0]   ip_wide;
   logic [AW:0]   off_wide;
   logic [AW-1:0] start_src;

   assign out_free = !out_valid_ff || rsp_bus.ready;
   assign s1_adv   = s1_valid_ff && out_free;
   assign issue_ok = !s1_valid_ff || s1_adv;

   // read data with forwarding of a same-cycle write
   assign s1_data = s1_lit_ff ? s1_byte_ff : (byp_hit_ff ? byp_data_ff : ram_rd);

   // match source, wrapped into the history
   assign ip_wide   = (AW+1)'(ip_ff);
   assign off_wide  = (AW+1)'(q_head.offset);
   assign start_src = (ip_wide >= off_wide) ? AW'(ip_wide - off_wide) :
                      AW'(ip_wide + (AW+1)'(HISTORY_DEPTH) - off_wide);

   lzfg_ram #(
      .WIDTH (8),
      .DEPTH (HISTORY_DEPTH)
   ) u_hist (
      .clock (clock),
      .we    (s1_adv),
      .waddr (wp_ff),
      .wdata (s1_data),
      .re    (re),
      .raddr (src_ff),
      .rdata (ram_rd)
   );

   // issue next byte: copy step, literal, or load a match
   always_comb begin
      copy_in     = copy_ff;
      src_in      = src_ff;
      cnt_in      = cnt_ff;
      done_in     = done_ff;
      ip_in       = ip_ff;
      s1_valid_in = s1_valid_ff && !s1_adv;
      s1_lit_in   = s1_lit_ff;
      s1_byte_in  = s1_byte_ff;
      s1_last_in  = s1_last_ff;
      s1_end_in   = s1_end_ff;
      q_pop       = 1'b0;
      re          = 1'b0;
      issue       = 1'b0;
      if (copy_ff) begin
         if (issue_ok) begin
            issue       = 1'b1;
            re          = 1'b1;
            s1_valid_in = 1'b1;
            s1_lit_in   = 1'b0;
            s1_last_in  = cnt_ff == lzfg_pkg::LEN_W'(1);
            s1_end_in   = done_ff && (cnt_ff == lzfg_pkg::LEN_W'(1));
            cnt_in      = cnt_ff - lzfg_pkg::LEN_W'(1);
            src_in      = (src_ff == LAST_ADDR) ? '0 : src_ff + AW'(1);
            copy_in     = cnt_ff != lzfg_pkg::LEN_W'(1);
         end
      end else if (!q_empty) begin
         if (q_head.is_copy) begin
            q_pop   = 1'b1;
            copy_in = 1'b1;
            src_in  = start_src;
            cnt_in  = q_head.count;
            done_in = q_head.done;
         end else if (issue_ok) begin
            q_pop       = 1'b1;
            issue       = 1'b1;
            s1_valid_in = 1'b1;
            s1_lit_in   = 1'b1;
            s1_byte_in  = q_head.lit_byte;
            s1_last_in  = 1'b1;
            s1_end_in   = q_head.done;
         end
      end
      if (issue) begin
         ip_in = (ip_ff == LAST_ADDR) ? '0 : ip_ff + AW'(1);
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         copy_ff      <= 1'b0;
         ip_ff        <= '0;
         wp_ff        <= '0;
         s1_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         copy_ff     <= copy_in;
         ip_ff       <= ip_in;
         s1_valid_ff <= s1_valid_in;
         if (s1_adv) begin
            wp_ff        <= (wp_ff == LAST_ADDR) ? '0 : wp_ff + AW'(1);
            out_valid_ff <= 1'b1;
         end else if (rsp_bus.ready) begin
            out_valid_ff <= 1'b0;
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      src_ff     <= src_in;
      cnt_ff     <= cnt_in;
      done_ff    <= done_in;
      s1_lit_ff  <= s1_lit_in;
      s1_byte_ff <= s1_byte_in;
      s1_last_ff <= s1_last_in;
      s1_end_ff  <= s1_end_in;
      if (re) begin
         byp_hit_ff  <= s1_adv && (wp_ff == src_ff);
         byp_data_ff <= s1_data;
      end
      if (s1_adv) begin
         out_byte_ff <= s1_data;
         out_last_ff <= s1_last_ff;
         out_end_ff  <= s1_end_ff;
      end
   end

   assign rsp_bus.valid      = out_valid_ff;
   assign rsp_bus.out_byte   = out_byte_ff;
   assign rsp_bus.run_last   = out_last_ff;
   assign rsp_bus.stream_end = out_end_ff;

endmodule

// File: rtl/lz_flag_group_decompressor_top.sv
// ----------------------------------------------------------------------------
// lz_flag_group_decompressor_top
// LZ decompressor with 32-bit flag words: parser, command queue, copy engine.
// ----------------------------------------------------------------------------
// Input: one compressed byte per cycle while the command queue has room.
// Literal: one output byte via the command queue, read stage and output register.
// Match: the copy engine loads the command, then issues one byte per cycle
// (1 to 34 after clipping) through the single history RAM read port, each via
// the read stage and output register; output stalls hold the copy engine.
// Reset clears all control state; history RAM contents stay undefined.
module lz_flag_group_decompressor_top #(
   parameter int HISTORY_DEPTH = 16384
) (
   input  logic        clock,
   input  logic        reset,
   lzfg_req_if.sink    req_bus,
   lzfg_rsp_if.source  rsp_bus
);

   logic              q_push;
   logic              q_pop;
   logic              q_full;
   logic              q_empty;
   lzfg_pkg::cmd_type q_push_cmd;
   lzfg_pkg::cmd_type q_head;

   lzfg_front u_front (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .q_full  (q_full),
      .q_push  (q_push),
      .q_cmd   (q_push_cmd)
   );

   lzfg_cmd_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (q_push),
      .push_cmd (q_push_cmd),
      .full     (q_full),
      .pop      (q_pop),
      .head     (q_head),
      .empty    (q_empty)
   );

   lzfg_back #(
      .HISTORY_DEPTH (HISTORY_DEPTH)
   ) u_back (
      .clock   (clock),
      .reset   (reset),
      .q_empty (q_empty),
      .q_head  (q_head),
      .q_pop   (q_pop),
      .rsp_bus (rsp_bus)
   );

   // a stream always ends on the last byte of a command
   a_end_is_last: assert property (@(posedge clock) disable iff (reset)
      rsp_bus.valid && rsp_bus.stream_end |-> rsp_bus.run_last)
      else $error("stream end without run last");

   // parser never overfills the queue
   a_no_push_full: assert property (@(posedge clock) disable iff (reset)
      q_push |-> !q_full)
      else $error("command push into full queue");

   // copy engine never pops an empty queue
   a_no_pop_empty: assert property (@(posedge clock) disable iff (reset)
      q_pop |-> !q_empty)
      else $error("command pop from empty queue");

endmodule
